### sv/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TPD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/tpd_pkg.sv
// Types, codes, constants and the CRC-32 byte update for the deframer.
// Depends on nothing; the top, front, queue and back of the block import it.
`timescale 1ns / 1ps
`default_nettype none

package tpd_pkg;

   // Header bytes in front of the payload: four id bytes, four CRC bytes.
   localparam int HEADER_BYTES = 8;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      CSR_TUNNEL_MODE  = 2'd0,
      CSR_TUNNEL_IDENT = 2'd1,
      CSR_PEER_HEADER  = 2'd2,
      CSR_SCRAMBLE_KEY = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_TOO_SHORT    = 3'd1,
      ST_HDR_MISMATCH = 3'd2,
      ST_CRC_MISMATCH = 3'd3,
      ST_TOO_LONG     = 3'd4
   } status_type;

   // One classified word handed from the front to the back.
   typedef struct packed {
      logic [7:0]  plain;       // descrambled byte
      logic        crc_feed;    // byte is payload and enters the CRC
      logic        emit;        // byte is delivered as payload
      logic        last;        // final byte of the datagram
      status_type  status;      // frame status before the CRC check
      logic [10:0] length;      // payload length, zero unless last
      logic [15:0] sender;      // sender id, zero unless last
      logic [31:0] stored_crc;  // CRC carried in the header
   } item_type;

   // Reflected CRC-32 update over one byte.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### sv/tpd_if.sv
// Channel interfaces of the deframer: byte input, result output, register writes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface tpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       rx_last;

   modport source (output valid, rx_byte, rx_last, input ready);
   modport sink   (input valid, rx_byte, rx_last, output ready);
endinterface

interface tpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  payload_byte;
   logic        payload_valid;
   logic        frame_end;
   logic [2:0]  frame_status;
   logic [10:0] payload_length;
   logic [15:0] sender_ident;

   modport source (output valid, payload_byte, payload_valid, frame_end, frame_status,
                   payload_length, sender_ident, input ready);
   modport sink   (input valid, payload_byte, payload_valid, frame_end, frame_status,
                   payload_length, sender_ident, output ready);
endinterface

interface tpd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/tunnel_packet_deframer_top.sv
// Top level of the tunnel datagram deframer: front, queue and back.
// Uses tpd_pkg, tpd_if, tpd_front, tpd_queue and tpd_back.
`timescale 1ns / 1ps
`default_nettype none

// The deframer takes one datagram byte per word on req_chan, the final byte
// marked by rx_last, and sustains one byte per clock cycle while the queue has
// room. The front checks the header, captures the stored CRC and descrambles
// payload bytes combinationally; the back updates the CRC-32 one byte per cycle
// while its result register can be drained, and that byte update sets the clock
// period. A payload byte is written into the queue at the edge that accepts it
// and moves into the result register when the back pops it; from there it is
// offered on rsp_chan. The result for the final byte carries status, length and
// sender id. Register writes on csr_chan are taken at once and should only be
// made between datagrams. QUEUE_DEPTH (2 or more) sets how many words the back
// can fall behind before the input stalls.

module tunnel_packet_deframer_top
   import tpd_pkg::*;
#(
   parameter int MAX_PAYLOAD = 1024,
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tpd_req_if.sink    req_chan,
   tpd_rsp_if.source  rsp_chan,
   tpd_csr_if.sink    csr_chan
);

   item_type push_item;
   item_type pop_item;
   logic     push_valid, push_ready;
   logic     pop_valid, pop_ready;

   // Classification of incoming bytes.
   tpd_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .item_out   (push_item),
      .item_valid (push_valid),
      .item_ready (push_ready)
   );

   // Decoupling queue.
   tpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // CRC check and result delivery.
   tpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

### sv/tpd_front.sv
// Front of the deframer: configuration registers, byte position tracking,
// header capture, descrambling and frame classification. Uses tpd_pkg, tpd_if.
`timescale 1ns / 1ps
`default_nettype none

module tpd_front
   import tpd_pkg::*;
#(
   parameter int MAX_PAYLOAD = 1024
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tpd_req_if.sink    req_chan,
   tpd_csr_if.sink    csr_chan,
   output item_type   item_out,
   output logic       item_valid,
   input  wire logic  item_ready
);

   localparam int LIMIT = MAX_PAYLOAD + HEADER_BYTES;
   localparam int CW    = $clog2(LIMIT + 2);
   localparam logic [CW-1:0] LIMIT_C = CW'(LIMIT);
   localparam logic [CW-1:0] MAX_C   = CW'(MAX_PAYLOAD);
   localparam logic [CW-1:0] HDR_C   = CW'(HEADER_BYTES);
   localparam logic [CW-1:0] CRC_POS = CW'(4);

   logic          mode_ff;
   logic [15:0]   ident_ff;
   logic [31:0]   peer_ff;
   logic [31:0]   key_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   header_ff, header_in;
   logic [31:0]   scrc_ff, scrc_in;
   logic          too_long_ff, too_long_in;

   logic          accept;
   logic          is_payload;
   logic [7:0]    plain;
   logic          match;
   logic [CW-1:0] len_full;
   logic [CW-1:0] len_sat;
   status_type    status;

   // Register writes are taken at once.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         ident_ff <= '0;
         peer_ff  <= '0;
         key_ff   <= '0;
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_TUNNEL_MODE:  mode_ff  <= csr_chan.data[0];
            CSR_TUNNEL_IDENT: ident_ff <= csr_chan.data[15:0];
            CSR_PEER_HEADER:  peer_ff  <= csr_chan.data;
            CSR_SCRAMBLE_KEY: key_ff   <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // A byte is taken whenever the queue has room.
   assign req_chan.ready = item_ready;
   assign accept         = req_chan.valid && item_ready;

   // Place the byte by its position in the datagram.
   always_comb begin
      header_in   = header_ff;
      scrc_in     = scrc_ff;
      too_long_in = too_long_ff;
      is_payload  = 1'b0;
      plain       = '0;
      if (count_ff < CRC_POS) begin
         header_in[8*count_ff[1:0] +: 8] = req_chan.rx_byte;
      end else if (count_ff < HDR_C) begin
         scrc_in[8*count_ff[1:0] +: 8] = req_chan.rx_byte;
      end else if (count_ff >= LIMIT_C) begin
         too_long_in = 1'b1;
      end else begin
         // The header is a multiple of four bytes, so the key lane follows the position.
         is_payload = 1'b1;
         plain      = req_chan.rx_byte ^ key_ff[8*count_ff[1:0] +: 8];
      end
   end

   // The count saturates just past the limit.
   assign count_in = (count_ff <= LIMIT_C) ? count_ff + 1'b1 : count_ff;

   assign match = mode_ff ? (header_in[31:16] == ident_ff) : (header_in == peer_ff);

   assign len_full = count_in - HDR_C;
   assign len_sat  = (len_full > MAX_C) ? MAX_C : len_full;

   // Frame status in priority order; the back adds the CRC verdict.
   always_comb begin
      if (count_in <= HDR_C) begin
         status = ST_TOO_SHORT;
      end else if (too_long_in) begin
         status = ST_TOO_LONG;
      end else if (!match) begin
         status = ST_HDR_MISMATCH;
      end else begin
         status = ST_OK;
      end
   end

   // Header bytes that do not end the datagram leave nothing for the back.
   assign item_valid = accept && (is_payload || req_chan.rx_last);

   always_comb begin
      item_out            = '0;
      item_out.plain      = plain;
      item_out.crc_feed   = is_payload;
      item_out.emit       = is_payload && match;
      item_out.last       = req_chan.rx_last;
      item_out.stored_crc = scrc_in;
      item_out.status     = ST_OK;
      if (req_chan.rx_last) begin
         item_out.status = status;
         item_out.length = (count_in <= HDR_C) ? 11'd0 : 11'(len_sat);
         item_out.sender = mode_ff ? header_in[15:0] : 16'd0;
      end
   end

   // Frame state advances per byte and clears after the final one.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         header_ff   <= '0;
         scrc_ff     <= '0;
         too_long_ff <= 1'b0;
      end else if (accept) begin
         if (req_chan.rx_last) begin
            count_ff    <= '0;
            header_ff   <= '0;
            scrc_ff     <= '0;
            too_long_ff <= 1'b0;
         end else begin
            count_ff    <= count_in;
            header_ff   <= header_in;
            scrc_ff     <= scrc_in;
            too_long_ff <= too_long_in;
         end
      end
   end

endmodule

`default_nettype wire

### sv/tpd_queue.sv
// Short queue of classified words between the front and the back.
// Uses tpd_pkg for the word type.
`timescale 1ns / 1ps
`default_nettype none

module tpd_queue
   import tpd_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  push_valid,
   output logic       push_ready,
   input  item_type   push_item,
   output logic       pop_valid,
   input  wire logic  pop_ready,
   output item_type   pop_item
);

   localparam int PW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [NW-1:0] FULL_N   = NW'(DEPTH);

   item_type      slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0] fill_ff;
   logic          push, pop;

   assign push_ready = (fill_ff != FULL_N);
   assign pop_valid  = (fill_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Pointers wrap at the depth; the fill level tracks push and pop.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

### sv/tpd_back.sv
// Back of the deframer: running CRC over the payload, final status and the
// result output register. Uses tpd_pkg, tpd_if and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tpd_back
   import tpd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  pop_valid,
   output logic       pop_ready,
   input  item_type   pop_item,
   tpd_rsp_if.source  rsp_chan
);

   logic        out_valid_ff;
   logic [31:0] crc_ff;
   logic [31:0] crc_in;
   logic [7:0]  byte_ff;
   logic        pvalid_ff;
   logic        end_ff;
   logic [2:0]  status_ff;
   logic [10:0] length_ff;
   logic [15:0] sender_ff;

   logic        pop;
   logic        has_result;
   status_type  status_fin;

   // A word is taken when the output register is empty or being drained.
   assign pop_ready  = !out_valid_ff || rsp_chan.ready;
   assign pop        = pop_valid && pop_ready;
   assign has_result = pop_item.emit || pop_item.last;

   assign crc_in = pop_item.crc_feed ? crc_byte(crc_ff, pop_item.plain) : crc_ff;

   // The CRC verdict only applies when no earlier check failed.
   always_comb begin
      status_fin = pop_item.status;
      if (pop_item.last && pop_item.status == ST_OK && ~crc_in != pop_item.stored_crc) begin
         status_fin = ST_CRC_MISMATCH;
      end
   end

   // Control: output valid and the running CRC, rearmed after each datagram.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         crc_ff       <= CRC_INIT;
      end else if (pop) begin
         out_valid_ff <= has_result;
         crc_ff       <= pop_item.last ? CRC_INIT : crc_in;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Result word.
   always_ff @(posedge clock) begin
      if (pop && has_result) begin
         byte_ff   <= pop_item.emit ? pop_item.plain : 8'd0;
         pvalid_ff <= pop_item.emit;
         end_ff    <= pop_item.last;
         status_ff <= status_fin;
         length_ff <= pop_item.length;
         sender_ff <= pop_item.sender;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.payload_byte   = byte_ff;
   assign rsp_chan.payload_valid  = pvalid_ff;
   assign rsp_chan.frame_end      = end_ff;
   assign rsp_chan.frame_status   = status_ff;
   assign rsp_chan.payload_length = length_ff;
   assign rsp_chan.sender_ident   = sender_ff;

   `TPD_ASSERT_IMPL(a_result_has_content, clock, reset, rsp_chan.valid,
      rsp_chan.payload_valid || rsp_chan.frame_end,
      "result word carries neither payload nor frame end")
   `TPD_ASSERT_IMPL(a_idle_byte_zero, clock, reset,
      rsp_chan.valid && !rsp_chan.payload_valid, rsp_chan.payload_byte == 8'd0,
      "payload byte not zero without payload")
   `TPD_ASSERT_IMPL(a_mid_frame_clean, clock, reset, rsp_chan.valid && !rsp_chan.frame_end,
      rsp_chan.frame_status == ST_OK && rsp_chan.payload_length == 11'd0 &&
      rsp_chan.sender_ident == 16'd0,
      "frame summary set before frame end")
   `TPD_ASSERT_NEXT(a_crc_rearm, clock, reset, pop && pop_item.last, crc_ff == CRC_INIT,
      "running CRC not rearmed after a datagram")

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the tunnel datagram deframer top level.
// Depends on tpd_pkg, the tpd_*_if channel interfaces and tunnel_packet_deframer_top.
`timescale 1ns / 1ps

module tb;
   import tpd_pkg::*;

   localparam int          MAX_PAYLOAD = 1024;
   localparam int unsigned FRAME_LIMIT = MAX_PAYLOAD + HEADER_BYTES;
   localparam logic [31:0] CRC32_REFLECTED = 32'hEDB8_8320;
   localparam int          HOLD_CYCLES = 400;
   localparam int          DRAIN_LIMIT = 400000;
   localparam int unsigned RANDOM_BUDGET = 40;

   typedef enum {FR_GOOD, FR_BAD_CRC, FR_BAD_HEADER, FR_SHORT, FR_NOISE} frame_kind_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } rx_word_type;

   typedef struct {
      logic [7:0]  payload_byte;
      logic        payload_valid;
      logic        frame_end;
      status_type  frame_status;
      logic [10:0] payload_length;
      logic [15:0] sender_ident;
   } deframe_result_type;

   logic clock = 1'b0;
   logic reset;

   tpd_req_if req_chan();
   tpd_rsp_if rsp_chan();
   tpd_csr_if csr_chan();

   tunnel_packet_deframer_top #(.MAX_PAYLOAD(MAX_PAYLOAD), .QUEUE_DEPTH(2)) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   // Mirror of the register file, updated when a register write is accepted.
   logic        cfg_tunnel_mode = 1'b0;
   logic [15:0] cfg_tunnel_ident = '0;
   logic [31:0] cfg_peer_header = '0;
   logic [31:0] cfg_scramble_key = '0;

   // Frame state of the predictor.
   int unsigned frm_count = 0;
   logic [31:0] frm_header = '0;
   logic [31:0] frm_crc_stored = '0;
   logic [31:0] frm_crc_run = 32'hFFFF_FFFF;
   logic        frm_overrun = 1'b0;

   rx_word_type        rx_words_queued[$];
   deframe_result_type awaited_results[$];

   int unsigned req_gap = 0;
   int unsigned rsp_gap = 0;
   int          hold_cnt = 0;
   bit          hold_arm;
   bit          idle_steady;
   int          error_count = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Reflected CRC-32, one data bit per step.
   function automatic logic [31:0] crc32_step(logic [31:0] crc, logic [7:0] data);
      logic [31:0] acc;
      logic        fb;
      acc = crc;
      for (int k = 0; k < 8; k++) begin
         fb = acc[0] ^ data[k];
         acc = {1'b0, acc[31:1]} ^ (fb ? CRC32_REFLECTED : 32'd0);
      end
      return acc;
   endfunction

   function automatic bit header_accepted();
      if (cfg_tunnel_mode)
         return frm_header[31:16] == cfg_tunnel_ident;
      return frm_header == cfg_peer_header;
   endfunction

   // Advance the predicted frame by one accepted byte and queue the word it causes.
   function automatic void deframe_byte(logic [7:0] b, logic last);
      int unsigned        pos;
      int unsigned        idx;
      logic [7:0]         plain;
      logic               emit;
      deframe_result_type res;
      pos = frm_count;
      plain = '0;
      emit = 1'b0;
      if (pos < 4) begin
         frm_header[8*pos +: 8] = b;
      end else if (pos < HEADER_BYTES) begin
         frm_crc_stored[8*(pos-4) +: 8] = b;
      end else if (pos >= FRAME_LIMIT) begin
         frm_overrun = 1'b1;
      end else begin
         idx = pos - HEADER_BYTES;
         plain = b ^ cfg_scramble_key[8*(idx%4) +: 8];
         frm_crc_run = crc32_step(frm_crc_run, plain);
         emit = header_accepted();
      end
      if (frm_count <= FRAME_LIMIT)
         frm_count++;

      res.payload_byte = emit ? plain : 8'd0;
      res.payload_valid = emit;
      res.frame_end = last;
      res.frame_status = ST_OK;
      res.payload_length = '0;
      res.sender_ident = '0;
      if (!last) begin
         if (emit)
            awaited_results.push_back(res);
         return;
      end

      // Final byte: status by priority, then the frame state starts over.
      if (frm_count <= HEADER_BYTES) begin
         res.frame_status = ST_TOO_SHORT;
      end else begin
         res.payload_length = (frm_count - HEADER_BYTES > MAX_PAYLOAD) ?
                              11'(MAX_PAYLOAD) : 11'(frm_count - HEADER_BYTES);
         if (frm_overrun)
            res.frame_status = ST_TOO_LONG;
         else if (!header_accepted())
            res.frame_status = ST_HDR_MISMATCH;
         else if (~frm_crc_run != frm_crc_stored)
            res.frame_status = ST_CRC_MISMATCH;
      end
      if (cfg_tunnel_mode)
         res.sender_ident = frm_header[15:0];
      awaited_results.push_back(res);
      frm_count = 0;
      frm_header = '0;
      frm_crc_stored = '0;
      frm_crc_run = 32'hFFFF_FFFF;
      frm_overrun = 1'b0;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 60)
         return 0;
      if (roll < 90)
         return $urandom_range(3, 1);
      return $urandom_range(30, 6);
   endfunction

   // Build one datagram against the current registers; returns its byte count.
   function automatic int unsigned queue_frame(frame_kind_type kind, int unsigned plen,
                                               int fill = -1);
      logic [7:0]  plain[$];
      logic [7:0]  raw[$];
      logic [31:0] hdr;
      logic [31:0] crc;
      rx_word_type w;
      if (kind == FR_SHORT || kind == FR_NOISE) begin
         for (int i = 0; i < plen; i++)
            raw.push_back(fill >= 0 ? fill[7:0] : 8'($urandom_range(255)));
      end else begin
         crc = 32'hFFFF_FFFF;
         for (int i = 0; i < plen; i++) begin
            plain.push_back(fill >= 0 ? fill[7:0] : 8'($urandom_range(255)));
            crc = crc32_step(crc, plain[i]);
         end
         crc = ~crc;
         hdr = cfg_tunnel_mode ? {cfg_tunnel_ident, 16'($urandom_range(65535))}
                               : cfg_peer_header;
         if (kind == FR_BAD_HEADER) begin
            if (cfg_tunnel_mode)
               hdr[31:16] ^= 16'($urandom_range(65535, 1));
            else
               hdr ^= 32'd1 << $urandom_range(31);
         end
         if (kind == FR_BAD_CRC)
            crc ^= 32'd1 << $urandom_range(31);
         for (int i = 0; i < 4; i++)
            raw.push_back(hdr[8*i +: 8]);
         for (int i = 0; i < 4; i++)
            raw.push_back(crc[8*i +: 8]);
         for (int i = 0; i < plen; i++)
            raw.push_back(plain[i] ^ cfg_scramble_key[8*(i%4) +: 8]);
      end
      foreach (raw[i]) begin
         w.data = raw[i];
         w.last = (i == raw.size() - 1);
         rx_words_queued.push_back(w);
      end
      return raw.size();
   endfunction

   // Mostly well-formed datagrams with random content, the rest broken or noise.
   function automatic void queue_random_frames(int unsigned budget);
      int unsigned sent;
      int unsigned roll;
      int unsigned plen;
      sent = 0;
      while (sent < budget) begin
         roll = $urandom_range(99);
         plen = $urandom_range(99) < 85 ? $urandom_range(24, 1) :
                $urandom_range(99) < 80 ? $urandom_range(120, 25) : $urandom_range(300, 121);
         if (roll < 70)
            sent += queue_frame(FR_GOOD, plen);
         else if (roll < 78)
            sent += queue_frame(FR_BAD_CRC, plen);
         else if (roll < 86)
            sent += queue_frame(FR_BAD_HEADER, plen);
         else if (roll < 94)
            sent += queue_frame(FR_SHORT, $urandom_range(8, 1));
         else
            sent += queue_frame(FR_NOISE, $urandom_range(20, 1));
      end
   endfunction

   function automatic void check_field(string name, logic [31:0] expv, logic [31:0] actv);
      if (actv !== expv) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expv, actv);
         error_count++;
      end
   endfunction

   // Byte sender: predicts each accepted word, then offers the next after a random gap.
   always @(posedge clock) begin
      rx_word_type nxt;
      logic        valid_next;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            deframe_byte(req_chan.rx_byte, req_chan.rx_last);
         if (req_chan.valid && !req_chan.ready) begin
            valid_next = 1'b1;
         end else if (req_gap != 0) begin
            valid_next = 1'b0;
            req_gap <= req_gap - 1;
         end else if (rx_words_queued.size() != 0) begin
            nxt = rx_words_queued.pop_front();
            req_chan.rx_byte <= nxt.data;
            req_chan.rx_last <= nxt.last;
            valid_next = 1'b1;
            req_gap <= idle_steady ? 0 : pick_gap();
         end else begin
            valid_next = 1'b0;
         end
         req_chan.valid <= valid_next;
      end
   end

   // Long receiver hold-off, started on request and counted here.
   always @(posedge clock) begin
      if (reset)
         hold_cnt <= 0;
      else if (hold_cnt > 0)
         hold_cnt <= hold_cnt - 1;
      else if (hold_arm)
         hold_cnt <= HOLD_CYCLES;
   end

   // Result receiver: checks each accepted word against the oldest prediction.
   always @(posedge clock) begin
      deframe_result_type want;
      logic               ready_next;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (awaited_results.size() == 0) begin
               $error("result word 0x%0h arrived with nothing awaited", rsp_chan.payload_byte);
               error_count++;
            end else begin
               want = awaited_results.pop_front();
               check_field("payload_byte", want.payload_byte, rsp_chan.payload_byte);
               check_field("payload_valid", want.payload_valid, rsp_chan.payload_valid);
               check_field("frame_end", want.frame_end, rsp_chan.frame_end);
               check_field("frame_status", want.frame_status, rsp_chan.frame_status);
               check_field("payload_length", want.payload_length, rsp_chan.payload_length);
               check_field("sender_ident", want.sender_ident, rsp_chan.sender_ident);
            end
         end
         if (rsp_gap != 0) begin
            rsp_gap <= rsp_gap - 1;
            ready_next = 1'b0;
         end else if (!idle_steady && $urandom_range(3) == 0) begin
            rsp_gap <= pick_gap();
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_chan.ready <= ready_next && (hold_cnt == 0);
      end
   end

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      case (idx)
         CSR_TUNNEL_MODE:  cfg_tunnel_mode = value[0];
         CSR_TUNNEL_IDENT: cfg_tunnel_ident = value[15:0];
         CSR_PEER_HEADER:  cfg_peer_header = value;
         CSR_SCRAMBLE_KEY: cfg_scramble_key = value;
         default: ;
      endcase
   endtask

   task automatic set_registers(logic mode, logic [15:0] ident, logic [31:0] peer,
                                logic [31:0] key);
      write_csr(CSR_TUNNEL_MODE, {31'd0, mode});
      write_csr(CSR_TUNNEL_IDENT, {16'd0, ident});
      write_csr(CSR_PEER_HEADER, peer);
      write_csr(CSR_SCRAMBLE_KEY, key);
      @(negedge clock);
   endtask

   // Hold off new bytes until every queued byte is taken and every result is in.
   task automatic wait_drained();
      int spins;
      spins = 0;
      do begin
         @(negedge clock);
         spins++;
      end while ((rx_words_queued.size() != 0 || req_chan.valid ||
                  awaited_results.size() != 0) && spins < DRAIN_LIMIT);
      repeat (8) @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      idle_steady = 1'b0;
      hold_arm = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.rx_byte = '0;
      req_chan.rx_last = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = CSR_TUNNEL_MODE;
      csr_chan.data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed datagrams under the reset register values.
      void'(queue_frame(FR_SHORT, 1, 8'hFF));
      void'(queue_frame(FR_GOOD, 0));
      void'(queue_frame(FR_GOOD, 1, 8'hFF));
      void'(queue_frame(FR_BAD_HEADER, 1, 8'h00));
      wait_drained();

      // Tunnel mode with every register at its top value.
      set_registers(1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      void'(queue_frame(FR_GOOD, 4, 8'h00));
      queue_random_frames(RANDOM_BUDGET);
      wait_drained();

      // Peer mode with no idling on either side.
      idle_steady = 1'b1;
      set_registers(1'b0, 16'($urandom), 32'hFFFF_FFFF, $urandom);
      queue_random_frames(RANDOM_BUDGET);
      wait_drained();
      idle_steady = 1'b0;

      set_registers(1'b1, 16'h0000, $urandom, 32'h0000_0000);
      queue_random_frames(RANDOM_BUDGET);
      wait_drained();

      // Receiver stalls for a long stretch while a datagram keeps coming,
      // then a payload one byte past the largest allowed.
      set_registers(1'b0, 16'($urandom), $urandom, $urandom);
      void'(queue_frame(FR_GOOD, 60));
      hold_arm = 1'b1;
      do @(negedge clock); while (hold_cnt == 0);
      hold_arm = 1'b0;
      void'(queue_frame(FR_GOOD, MAX_PAYLOAD + 1));
      queue_random_frames(RANDOM_BUDGET);
      wait_drained();

      set_registers(1'b1, 16'($urandom), $urandom, $urandom);
      queue_random_frames(RANDOM_BUDGET);
      wait_drained();

      if (awaited_results.size() != 0 || rx_words_queued.size() != 0) begin
         $error("%0d results still awaited, %0d bytes unsent at end of run",
                awaited_results.size(), rx_words_queued.size());
         error_count++;
      end
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Run limit, well beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
